// ===== sv/segment_intersection_top_macros.svh =====
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sit_pkg.sv =====
// Package with constants for the segment intersection block.
`default_nettype none
package sit_pkg;
    localparam int SIT_COORD_WIDTH = 32;
    localparam int FIELD_W         = 32;
    localparam int S_DATA_W        = 8 * FIELD_W;
    localparam int M_DATA_W        = 72;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam logic [APB_ADDR_W-3:0] REG_PARALLEL_EPSILON = 1'b0;
    localparam logic [31:0] EPSILON_RESET = 32'd4295;
endpackage
`default_nettype wire

// ===== sv/segment_intersection_top.sv =====
// Pipelined 2D segment intersection test with crossing point.
//
//  Port group | Direction | Carries
//  s_*        | in        | one segment pair per transaction
//  m_*        | out       | hit flag and crossing point per transaction
//  p*         | in/out    | register access (parallel_epsilon)
//
// One transaction is accepted per cycle unless m_tready stalls the pipeline.
// Four arithmetic stages, COORD_WIDTH + 1 quotient stages and one output stage.
// The depth is set by the quotient for the crossing point, one bit per stage.
// Reset is synchronous and clears only the valid bits and the register.
// A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module segment_intersection_top #(
    parameter int COORD_WIDTH = sit_pkg::SIT_COORD_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x,
    // b_end_y, 32 bits each from the lowest bit up
    input  wire logic [sit_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hit [0], cross_x [32:1], cross_y [64:33], zero padding [71:65]
    output logic [sit_pkg::M_DATA_W-1:0]           m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sit_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [sit_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sit_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import sit_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DFW  = CW + 1;
    localparam int PRW  = 2 * DFW;
    localparam int XW   = PRW + 1;
    localparam int RW   = XW + 2;
    localparam int BW   = DFW;
    localparam int QW   = DFW + 1;
    localparam int SW   = QW + 2;
    localparam int NDIV = BW;

    // Configuration register
    logic [31:0] eps_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_PARALLEL_EPSILON);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_PARALLEL_EPSILON) ? eps_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPSILON_RESET;
        end else if (cfg_wr) begin
            eps_reg <= pwdata;
        end
    end

    logic ce;
    logic m_valid_reg;
    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    // Coordinate extraction
    logic signed [CW-1:0] c [8];
    genvar gi;
    generate
        for (gi = 0; gi < 8; gi++) begin : g_ext
            if (CW <= FIELD_W) begin : g_narrow
                assign c[gi] = s_tdata[gi*FIELD_W +: CW];
            end else begin : g_wide
                assign c[gi] = {{(CW-FIELD_W){1'b0}}, s_tdata[gi*FIELD_W +: FIELD_W]};
            end
        end
    endgenerate

    // Stage 1: differences
    logic                  v1_reg;
    logic signed [CW-1:0]  ax1_reg, ay1_reg;
    logic signed [DFW-1:0] rx1_reg, ry1_reg, sx1_reg, sy1_reg, dx1_reg, dy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax1_reg <= c[0];
            ay1_reg <= c[1];
            rx1_reg <= {c[2][CW-1], c[2]} - {c[0][CW-1], c[0]};
            ry1_reg <= {c[3][CW-1], c[3]} - {c[1][CW-1], c[1]};
            sx1_reg <= {c[6][CW-1], c[6]} - {c[4][CW-1], c[4]};
            sy1_reg <= {c[7][CW-1], c[7]} - {c[5][CW-1], c[5]};
            dx1_reg <= {c[4][CW-1], c[4]} - {c[0][CW-1], c[0]};
            dy1_reg <= {c[5][CW-1], c[5]} - {c[1][CW-1], c[1]};
        end
    end

    // Stage 2: the six products
    logic                  v2_reg;
    logic signed [CW-1:0]  ax2_reg, ay2_reg;
    logic signed [DFW-1:0] rx2_reg, ry2_reg;
    logic signed [PRW-1:0] p_rxsy_reg, p_rysx_reg, p_dxsy_reg, p_dysx_reg;
    logic signed [PRW-1:0] p_dxry_reg, p_dyrx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            rx2_reg    <= rx1_reg;
            ry2_reg    <= ry1_reg;
            p_rxsy_reg <= rx1_reg * sy1_reg;
            p_rysx_reg <= ry1_reg * sx1_reg;
            p_dxsy_reg <= dx1_reg * sy1_reg;
            p_dysx_reg <= dy1_reg * sx1_reg;
            p_dxry_reg <= dx1_reg * ry1_reg;
            p_dyrx_reg <= dy1_reg * rx1_reg;
        end
    end

    // Stage 3: cross products
    logic                  v3_reg;
    logic signed [CW-1:0]  ax3_reg, ay3_reg;
    logic signed [DFW-1:0] rx3_reg, ry3_reg;
    logic signed [XW-1:0]  den3_reg, tn3_reg, un3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ce) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            rx3_reg  <= rx2_reg;
            ry3_reg  <= ry2_reg;
            den3_reg <= {p_rxsy_reg[PRW-1], p_rxsy_reg} - {p_rysx_reg[PRW-1], p_rysx_reg};
            tn3_reg  <= {p_dxsy_reg[PRW-1], p_dxsy_reg} - {p_dysx_reg[PRW-1], p_dysx_reg};
            un3_reg  <= {p_dxry_reg[PRW-1], p_dxry_reg} - {p_dyrx_reg[PRW-1], p_dyrx_reg};
        end
    end

    // Stage 4: parallel test and range tests on both parameters
    logic [XW-1:0]  den_mag, tn_mag, un_mag;
    logic           den_ok, t_ok, u_ok, hit_next;

    assign den_mag = den3_reg[XW-1] ? XW'(-den3_reg) : XW'(den3_reg);
    assign tn_mag  = tn3_reg[XW-1]  ? XW'(-tn3_reg)  : XW'(tn3_reg);
    assign un_mag  = un3_reg[XW-1]  ? XW'(-un3_reg)  : XW'(un3_reg);
    // A zero cross product is parallel even with a zero threshold.
    assign den_ok  = (den_mag != '0) && (den_mag >= {{(XW-32){1'b0}}, eps_reg});
    assign t_ok    = (tn3_reg == '0) ||
                     ((tn3_reg[XW-1] == den3_reg[XW-1]) && (tn_mag <= den_mag));
    assign u_ok    = (un3_reg == '0) ||
                     ((un3_reg[XW-1] == den3_reg[XW-1]) && (un_mag <= den_mag));
    assign hit_next = den_ok && t_ok && u_ok;

    logic                 v4_reg, hit4_reg;
    logic signed [CW-1:0] ax4_reg, ay4_reg;
    logic [BW-1:0]        bx4_reg, by4_reg;
    logic                 nx4_reg, ny4_reg;
    logic [XW-1:0]        tm4_reg, dm4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            hit4_reg <= hit_next;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            nx4_reg  <= rx3_reg[DFW-1];
            ny4_reg  <= ry3_reg[DFW-1];
            bx4_reg  <= rx3_reg[DFW-1] ? BW'(-rx3_reg) : BW'(rx3_reg);
            by4_reg  <= ry3_reg[DFW-1] ? BW'(-ry3_reg) : BW'(ry3_reg);
            tm4_reg  <= tn_mag;
            dm4_reg  <= den_mag;
        end
    end

    // Quotient stages: floor(|tnum| * |dir| / |den|), one bit of |dir| per stage.
    // Since |tnum| <= |den| the partial remainder stays below three times |den|.
    logic                 dv_v_reg   [NDIV];
    logic                 dv_hit_reg [NDIV];
    logic signed [CW-1:0] dv_ax_reg  [NDIV];
    logic signed [CW-1:0] dv_ay_reg  [NDIV];
    logic                 dv_nx_reg  [NDIV];
    logic                 dv_ny_reg  [NDIV];
    logic [BW-1:0]        dv_bx_reg  [NDIV];
    logic [BW-1:0]        dv_by_reg  [NDIV];
    logic [XW-1:0]        dv_a_reg   [NDIV];
    logic [XW-1:0]        dv_d_reg   [NDIV];
    logic [XW-1:0]        dv_rx_reg  [NDIV];
    logic [XW-1:0]        dv_ry_reg  [NDIV];
    logic [QW-1:0]        dv_qx_reg  [NDIV];
    logic [QW-1:0]        dv_qy_reg  [NDIV];

    genvar gk;
    generate
        for (gk = 0; gk < NDIV; gk++) begin : g_div
            logic                 in_v, in_hit, in_nx, in_ny;
            logic signed [CW-1:0] in_ax, in_ay;
            logic [BW-1:0]        in_bx, in_by;
            logic [XW-1:0]        in_a, in_d, in_rx, in_ry;
            logic [QW-1:0]        in_qx, in_qy;
            logic [RW-1:0]        sx, sy, d1, d2;
            logic [XW-1:0]        rx_next, ry_next;
            logic [1:0]           gx, gy;

            if (gk == 0) begin : g_first
                assign in_v   = v4_reg;
                assign in_hit = hit4_reg;
                assign in_ax  = ax4_reg;
                assign in_ay  = ay4_reg;
                assign in_nx  = nx4_reg;
                assign in_ny  = ny4_reg;
                assign in_bx  = bx4_reg;
                assign in_by  = by4_reg;
                assign in_a   = tm4_reg;
                assign in_d   = dm4_reg;
                assign in_rx  = '0;
                assign in_ry  = '0;
                assign in_qx  = '0;
                assign in_qy  = '0;
            end else begin : g_next
                assign in_v   = dv_v_reg[gk-1];
                assign in_hit = dv_hit_reg[gk-1];
                assign in_ax  = dv_ax_reg[gk-1];
                assign in_ay  = dv_ay_reg[gk-1];
                assign in_nx  = dv_nx_reg[gk-1];
                assign in_ny  = dv_ny_reg[gk-1];
                assign in_bx  = dv_bx_reg[gk-1];
                assign in_by  = dv_by_reg[gk-1];
                assign in_a   = dv_a_reg[gk-1];
                assign in_d   = dv_d_reg[gk-1];
                assign in_rx  = dv_rx_reg[gk-1];
                assign in_ry  = dv_ry_reg[gk-1];
                assign in_qx  = dv_qx_reg[gk-1];
                assign in_qy  = dv_qy_reg[gk-1];
            end

            assign d1 = {2'b00, in_d};
            assign d2 = {1'b0, in_d, 1'b0};
            assign sx = {1'b0, in_rx, 1'b0}
                        + (in_bx[BW-1-gk] ? {2'b00, in_a} : '0);
            assign sy = {1'b0, in_ry, 1'b0}
                        + (in_by[BW-1-gk] ? {2'b00, in_a} : '0);

            always_comb begin
                priority if (sx >= d2) begin
                    gx      = 2'd2;
                    rx_next = XW'(sx - d2);
                end else if (sx >= d1) begin
                    gx      = 2'd1;
                    rx_next = XW'(sx - d1);
                end else begin
                    gx      = 2'd0;
                    rx_next = XW'(sx);
                end
                priority if (sy >= d2) begin
                    gy      = 2'd2;
                    ry_next = XW'(sy - d2);
                end else if (sy >= d1) begin
                    gy      = 2'd1;
                    ry_next = XW'(sy - d1);
                end else begin
                    gy      = 2'd0;
                    ry_next = XW'(sy);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_v_reg[gk] <= 1'b0;
                end else if (ce) begin
                    dv_v_reg[gk] <= in_v;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    dv_hit_reg[gk] <= in_hit;
                    dv_ax_reg[gk]  <= in_ax;
                    dv_ay_reg[gk]  <= in_ay;
                    dv_nx_reg[gk]  <= in_nx;
                    dv_ny_reg[gk]  <= in_ny;
                    dv_bx_reg[gk]  <= in_bx;
                    dv_by_reg[gk]  <= in_by;
                    dv_a_reg[gk]   <= in_a;
                    dv_d_reg[gk]   <= in_d;
                    dv_rx_reg[gk]  <= rx_next;
                    dv_ry_reg[gk]  <= ry_next;
                    dv_qx_reg[gk]  <= {in_qx[QW-2:0], 1'b0} + {{(QW-2){1'b0}}, gx};
                    dv_qy_reg[gk]  <= {in_qy[QW-2:0], 1'b0} + {{(QW-2){1'b0}}, gy};
                end
            end
        end
    endgenerate

    // Output stage: add the signed offset to the start point and saturate.
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (CW - 1)));

    logic signed [SW-1:0] ex, ey, sum_x, sum_y;
    logic signed [CW-1:0] sat_x, sat_y;
    logic [31:0]          out_x, out_y;

    assign ex    = {{(SW-QW){1'b0}}, dv_qx_reg[NDIV-1]};
    assign ey    = {{(SW-QW){1'b0}}, dv_qy_reg[NDIV-1]};
    assign sum_x = {{(SW-CW){dv_ax_reg[NDIV-1][CW-1]}}, dv_ax_reg[NDIV-1]}
                   + (dv_nx_reg[NDIV-1] ? -ex : ex);
    assign sum_y = {{(SW-CW){dv_ay_reg[NDIV-1][CW-1]}}, dv_ay_reg[NDIV-1]}
                   + (dv_ny_reg[NDIV-1] ? -ey : ey);
    assign sat_x = (sum_x > SAT_HI) ? CW'(SAT_HI) : (sum_x < SAT_LO) ? CW'(SAT_LO)
                   : CW'(sum_x);
    assign sat_y = (sum_y > SAT_HI) ? CW'(SAT_HI) : (sum_y < SAT_LO) ? CW'(SAT_LO)
                   : CW'(sum_y);

    generate
        if (CW >= 32) begin : g_out_trunc
            assign out_x = sat_x[31:0];
            assign out_y = sat_y[31:0];
        end else begin : g_out_sext
            assign out_x = {{(32-CW){sat_x[CW-1]}}, sat_x};
            assign out_y = {{(32-CW){sat_y[CW-1]}}, sat_y};
        end
    endgenerate

    logic        m_hit_reg;
    logic [31:0] m_x_reg, m_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= dv_v_reg[NDIV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_hit_reg <= dv_hit_reg[NDIV-1];
            m_x_reg   <= dv_hit_reg[NDIV-1] ? out_x : '0;
            m_y_reg   <= dv_hit_reg[NDIV-1] ? out_y : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_y_reg, m_x_reg, m_hit_reg};

`include "segment_intersection_top_macros.svh"

    `SIT_ASSERT_NOW(a_nohit_zero, m_valid_reg && !m_hit_reg, (m_x_reg == '0) && (m_y_reg == '0), "point not zero without a hit")
    `SIT_ASSERT_NOW(a_zero_den_nohit, v3_reg && (den3_reg == '0), !hit_next, "hit on a zero cross product")
    `SIT_ASSERT_NEXT(a_stall_holds, !ce, $stable(v4_reg) && $stable(dv_v_reg[NDIV-1]), "pipeline moved during a stall")

endmodule
`default_nettype wire

// ===== test/tb_segment_intersection_top.sv =====
// Testbench for the segment intersection block: scoreboard, directed and random stimulus, idling.
`timescale 1ns / 100ps

module tb_segment_intersection_top;
    import sit_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [31:0] coord_t;

    typedef struct {
        coord_t c [8];
    } seg_pair_t;

    typedef struct {
        logic   hit;
        coord_t x;
        coord_t y;
    } crossing_t;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_GAP   = 45;

    class crossing_scoreboard;
        crossing_t   pending [$];
        logic [31:0] epsilon;
        int          mismatches;

        function new();
            epsilon    = EPSILON_RESET;
            mismatches = 0;
        endfunction

        function wide_t mag(wide_t v);
            return (v < 0) ? -v : v;
        endfunction

        function wide_t cross_prod(wide_t ax, wide_t ay, wide_t bx, wide_t by);
            return ax * by - ay * bx;
        endfunction

        function bit within_unit(wide_t num, wide_t den);
            if (num == 0) return 1;
            if ((num < 0) != (den < 0)) return 0;
            return mag(num) <= mag(den);
        endfunction

        function coord_t axis_point(wide_t start, wide_t dir, wide_t tmag, wide_t dmag);
            logic [127:0] q;
            wide_t        v;
            q = (tmag * mag(dir)) / dmag;
            v = (dir < 0) ? start - wide_t'(q) : start + wide_t'(q);
            if (v > 128'sh7FFF_FFFF) v = 128'sh7FFF_FFFF;
            if (v < -128'sh8000_0000) v = -128'sh8000_0000;
            return v[31:0];
        endfunction

        function void note_pair(seg_pair_t p);
            wide_t     ax, ay, rx, ry, sx, sy, dx, dy, den, tnum, unum;
            crossing_t r;
            ax = p.c[0];
            ay = p.c[1];
            rx = wide_t'(p.c[2]) - ax;
            ry = wide_t'(p.c[3]) - ay;
            sx = wide_t'(p.c[6]) - wide_t'(p.c[4]);
            sy = wide_t'(p.c[7]) - wide_t'(p.c[5]);
            dx = wide_t'(p.c[4]) - ax;
            dy = wide_t'(p.c[5]) - ay;
            den = cross_prod(rx, ry, sx, sy);
            r = '{hit: 1'b0, x: '0, y: '0};
            if (den != 0 && mag(den) >= wide_t'({96'd0, epsilon})) begin
                tnum = cross_prod(dx, dy, sx, sy);
                unum = cross_prod(dx, dy, rx, ry);
                if (within_unit(tnum, den) && within_unit(unum, den)) begin
                    r.hit = 1'b1;
                    r.x   = axis_point(ax, rx, mag(tnum), mag(den));
                    r.y   = axis_point(ay, ry, mag(tnum), mag(den));
                end
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            crossing_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.hit || d[32:1] !== e.x || d[64:33] !== e.y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected hit %0b x %h y %h, got hit %0b x %h y %h",
                             e.hit, e.x, e.y, d[0], d[32:1], d[64:33]);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    crossing_scoreboard sb;
    seg_pair_t          in_flight;
    int                 pairs_taken;
    int                 idle_cycles;
    bit                 quiet;
    int                 sink_stall;

    segment_intersection_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Monitor: both channels are sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_pair(in_flight);
                pairs_taken++;
            end
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Result side back-pressure in short random bursts.
    always @(negedge aclk) begin
        if (sink_stall > 0 && !quiet) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) sink_stall = $urandom_range(1, 3);
        end
    end

    task automatic send_pair(seg_pair_t p);
        int gap;
        int taken;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge aclk);
        end
        in_flight = p;
        for (int i = 0; i < 8; i++) s_tdata[32*i +: 32] = p.c[i];
        s_tvalid = 1'b1;
        taken = pairs_taken;
        do begin
            @(posedge aclk);
            #1;
        end while (pairs_taken == taken);
    endtask

    task automatic release_source();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        release_source();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == {REG_PARALLEL_EPSILON, 2'b00}) sb.epsilon = value;
    endtask

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t near(int span);
        return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
    endfunction

    // Mostly pairs built to cross, with parallel, degenerate and unrelated pairs as noise.
    function automatic seg_pair_t make_pair();
        seg_pair_t p;
        int        span;
        int        f;
        coord_t    px, py, vx, vy;
        span = ($urandom_range(0, 3) == 0) ? 32'h3FFF_FFFF : (1 << $urandom_range(4, 24));
        for (int i = 0; i < 8; i++) p.c[i] = near(span);
        case ($urandom_range(0, 9))
            0: for (int i = 0; i < 8; i++) p.c[i] = coord_t'($urandom);
            1: for (int i = 0; i < 8; i++) p.c[i] = pick_extreme();
            2: begin
                f = int'($urandom_range(0, 6)) - 3;
                p.c[6] = p.c[4] + f * (p.c[2] - p.c[0]);
                p.c[7] = p.c[5] + f * (p.c[3] - p.c[1]);
            end
            3: begin
                p.c[2] = p.c[0];
                p.c[3] = p.c[1];
            end
            default: begin
                f  = $urandom_range(0, 256);
                px = p.c[0] + coord_t'((longint'(p.c[2] - p.c[0]) * f) >>> 8);
                py = p.c[1] + coord_t'((longint'(p.c[3] - p.c[1]) * f) >>> 8);
                vx = near(span / 2);
                vy = near(span / 2);
                p.c[4] = px - vx;
                p.c[5] = py - vy;
                p.c[6] = px + vx;
                p.c[7] = py + vy;
            end
        endcase
        return p;
    endfunction

    task automatic random_pairs(int n);
        repeat (n) send_pair(make_pair());
    endtask

    task automatic directed_pairs();
        seg_pair_t p;
        // Crossing at the origin, touching at end points, and a near miss.
        p.c = '{-32'sh10000, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000};
        send_pair(p);
        p.c = '{0, 0, 32'sh20000, 0, 32'sh20000, 0, 32'sh20000, 32'sh30000};
        send_pair(p);
        p.c = '{0, 0, 32'sh10000, 0, 32'sh10001, -5, 32'sh10001, 5};
        send_pair(p);
        // Parallel, collinear and zero-length segments.
        p.c = '{0, 0, 100, 100, 0, 10, 100, 110};
        send_pair(p);
        p.c = '{0, 0, 100, 100, 50, 50, 150, 150};
        send_pair(p);
        p.c = '{7, 7, 7, 7, 0, 0, 20, 20};
        send_pair(p);
        // Tiny cross product just around the default threshold.
        p.c = '{0, 0, 65, 0, 0, -33, 1, 33};
        send_pair(p);
        p.c = '{0, 0, 66, 0, 30, -33, 31, 33};
        send_pair(p);
        // Whole-range segments: end points at the limits, the crossing point near the middle.
        p.c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_pair(p);
        p.c = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
        send_pair(p);
        p.c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
        send_pair(p);
        // Negative directions that need truncation toward zero.
        p.c = '{10, 10, -11, -1, -3, 20, 0, -20};
        send_pair(p);
        p.c = '{0, 0, -1, 0, -1, 0, 0, 0};
        send_pair(p);
        p.c = '{-1, -1, -1, -1, -1, -1, -1, -1};
        send_pair(p);
        p.c = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_pair(p);
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 8; j++) p.c[j] = pick_extreme();
            send_pair(p);
        end
    endtask

    initial begin
        sb          = new();
        pairs_taken = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        sink_stall  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed_pairs();
        random_pairs(150);
        drain();

        write_reg({REG_PARALLEL_EPSILON, 2'b00}, 32'd0);
        directed_pairs();
        random_pairs(130);
        drain();

        write_reg({REG_PARALLEL_EPSILON, 2'b00}, 32'hFFFF_FFFF);
        random_pairs(100);
        drain();

        write_reg({REG_PARALLEL_EPSILON, 2'b00}, $urandom);
        // A write to an unused address must leave the threshold alone.
        write_reg(3'd4, 32'h0000_0001);
        random_pairs(120);
        drain();

        write_reg({REG_PARALLEL_EPSILON, 2'b00}, EPSILON_RESET);
        random_pairs(60);
        quiet = 1'b1;
        random_pairs(90);
        release_source();

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
